// File: hw/rtl/bde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bde_pkg
// Shared types and codes of the bounded double-ended queue: operation codes,
// result status codes and the control word that steers the cell chain.
// ----------------------------------------------------------------------------
package bde_pkg;

   typedef logic signed [31:0] word_type;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_LIST       = 3'd4
   } op_type;

   typedef logic [1:0] status_type;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   // One cycle's move of the whole chain; at most one member is set.
   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pop_front;
      logic rotate;
   } ctrl_type;

endpackage
`default_nettype wire

// File: hw/rtl/bounded_deque_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque_engine_unit
// Bounded double-ended queue of signed 32-bit words, held in a chain of cells
// with the front word always in cell zero.
// ----------------------------------------------------------------------------
//   channel   direction   handshake             payload
//   req       in          req_valid/req_ready   req_operation, req_word_in
//   rsp       out         rsp_valid/rsp_ready   rsp_word_out, rsp_status, rsp_last
//
// A push or pop is taken and its result shows on rsp in the next cycle.
// A list enters the list state and then sends one held word whenever rsp is
// free, as the chain turns by one cell each time the front word is sent out.
// Unused operation codes are taken and give no word.
// Reset empties the queue; the cell contents are not cleared.
// A stalled rsp holds the result and keeps req_ready low.
module bounded_deque_engine_unit #(
   parameter int DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_operation,
   input  wire bde_pkg::word_type  req_word_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output bde_pkg::word_type       rsp_word_out,
   output bde_pkg::status_type     rsp_status,
   output logic                    rsp_last
);
   import bde_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   typedef enum logic {S_IDLE, S_LIST} state_type;

   state_type      state_ff;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  list_left_ff;
   logic           rsp_valid_ff;
   word_type       rsp_word_out_ff;
   status_type     rsp_status_ff;
   logic           rsp_last_ff;

   ctrl_type       ctrl;
   logic           rsp_load;
   logic           out_free;
   logic           accept;
   logic           full;
   logic           empty;
   word_type       cell_word [DEPTH];
   word_type       back_chain [DEPTH+1];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == DEPTH_C);
   assign empty     = (count_ff == '0);

   always_comb begin
      ctrl     = '0;
      rsp_load = 1'b0;
      if (accept) begin
         unique case (op_type'(req_operation))
            OP_PUSH_FRONT: begin
               ctrl.push_front = !full;
               rsp_load        = 1'b1;
            end
            OP_PUSH_BACK: begin
               ctrl.push_back = !full;
               rsp_load       = 1'b1;
            end
            OP_POP_FRONT: begin
               ctrl.pop_front = !empty;
               rsp_load       = 1'b1;
            end
            OP_POP_BACK:  rsp_load = 1'b1;
            OP_LIST:      rsp_load = empty;
            default: ;
         endcase
      end
      if ((state_ff == S_LIST) && out_free) begin
         ctrl.rotate = 1'b1;
         rsp_load    = 1'b1;
      end
   end

   assign back_chain[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      word_type left_word;
      word_type right_word;
      if (i == 0) begin : g_first
         assign left_word = req_word_in;
      end else begin : g_mid_left
         assign left_word = cell_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_word = cell_word[i];
      end else begin : g_mid_right
         assign right_word = cell_word[i+1];
      end
      bde_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .word_in    (req_word_in),
         .left_word  (left_word),
         .right_word (right_word),
         .head_word  (cell_word[0]),
         .back_in    (back_chain[i]),
         .word_out   (cell_word[i]),
         .back_out   (back_chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         list_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (op_type'(req_operation))
                     OP_PUSH_FRONT, OP_PUSH_BACK: begin
                        rsp_valid_ff    <= 1'b1;
                        rsp_word_out_ff <= '0;
                        rsp_last_ff     <= 1'b1;
                        rsp_status_ff   <= full ? ST_FULL : ST_OK;
                        if (!full) begin
                           count_ff <= count_ff + CW'(1);
                        end
                     end
                     OP_POP_FRONT, OP_POP_BACK: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_last_ff  <= 1'b1;
                        if (empty) begin
                           rsp_word_out_ff <= '0;
                           rsp_status_ff   <= ST_EMPTY;
                        end else begin
                           rsp_word_out_ff <= (op_type'(req_operation) == OP_POP_FRONT)
                                              ? cell_word[0] : back_chain[DEPTH];
                           rsp_status_ff   <= ST_OK;
                           count_ff        <= count_ff - CW'(1);
                        end
                     end
                     OP_LIST: begin
                        if (empty) begin
                           rsp_valid_ff    <= 1'b1;
                           rsp_word_out_ff <= '0;
                           rsp_status_ff   <= ST_EMPTY;
                           rsp_last_ff     <= 1'b1;
                        end else begin
                           state_ff     <= S_LIST;
                           list_left_ff <= count_ff;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_LIST: begin
               // The head word goes out while the chain turns it to the back.
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_word_out_ff <= cell_word[0];
                  rsp_status_ff   <= ST_OK;
                  rsp_last_ff     <= (list_left_ff == CW'(1));
                  list_left_ff    <= list_left_ff - CW'(1);
                  if (list_left_ff == CW'(1)) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word_out = rsp_word_out_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;

endmodule
`default_nettype wire

// File: hw/rtl/bde_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bde_cell
// One slot of the queue chain. It takes a word from its left or right
// neighbor, from the input, or from the head cell, as the chain control says,
// and adds its word to the back-word collection chain when it is the back.
// ----------------------------------------------------------------------------
module bde_cell #(
   parameter int DEPTH = 16,
   parameter int INDEX = 0
) (
   input  wire logic              clock,
   input  wire bde_pkg::ctrl_type ctrl,
   input  wire logic [$clog2(DEPTH+1)-1:0] count,
   input  wire bde_pkg::word_type word_in,
   input  wire bde_pkg::word_type left_word,
   input  wire bde_pkg::word_type right_word,
   input  wire bde_pkg::word_type head_word,
   input  wire bde_pkg::word_type back_in,
   output bde_pkg::word_type      word_out,
   output bde_pkg::word_type      back_out
);
   import bde_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

   word_type        word_ff;
   word_type        word_in_sel;
   logic            word_we;
   logic [CW-1:0]   count_m1;
   logic            is_back;

   // With an empty queue count_m1 wraps above every index, so no cell is back.
   assign count_m1 = count - CW'(1);
   assign is_back  = (MY_INDEX == count_m1);

   always_comb begin
      word_we     = 1'b0;
      word_in_sel = word_ff;
      priority if (ctrl.push_front) begin
         word_we     = 1'b1;
         word_in_sel = left_word;
      end else if (ctrl.push_back) begin
         word_we     = (MY_INDEX == count);
         word_in_sel = word_in;
      end else if (ctrl.pop_front) begin
         word_we     = 1'b1;
         word_in_sel = right_word;
      end else if (ctrl.rotate) begin
         // Only the held part of the chain turns; the back takes the head.
         if (MY_INDEX < count_m1) begin
            word_we     = 1'b1;
            word_in_sel = right_word;
         end else if (is_back) begin
            word_we     = 1'b1;
            word_in_sel = head_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (word_we) begin
         word_ff <= word_in_sel;
      end
   end

   assign word_out = word_ff;
   assign back_out = is_back ? (back_in | word_ff) : back_in;

endmodule
`default_nettype wire

// File: hw/rtl/bde_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bde_checker
// Port-level checks of the deque unit: result hold under stall, status and
// word consistency, and no new word taken while a result is stuck.
// ----------------------------------------------------------------------------
module bde_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire bde_pkg::word_type   rsp_word_out,
   input wire bde_pkg::status_type rsp_status,
   input wire logic                rsp_last
);
   import bde_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word_out)
         && $stable(rsp_status) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_last)
      else $error("empty or full result not marked last");

   a_err_zero_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_word_out == '0))
      else $error("empty or full result carries a word");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_EMPTY)
         || (rsp_status == ST_FULL))
      else $error("undefined status code");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_ready)
      else $error("request taken while a result is stuck");

endmodule

bind bounded_deque_engine_unit bde_checker u_bde_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_word_out (rsp_word_out),
   .rsp_status   (rsp_status),
   .rsp_last     (rsp_last)
);
`default_nettype wire

// File: dv/bounded_deque_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// bounded_deque_engine_unit_tb
// Self-checking bench for the bounded double-ended queue. Requests are queued
// by a stimulus block and presented by a falling-edge driver. A rising-edge
// monitor keeps a shadow ring of the queue, predicts every answer word when a
// request is taken, and compares each answer word field by field in order.
// ----------------------------------------------------------------------------
module bounded_deque_engine_unit_tb;
   import bde_pkg::*;

   localparam int DEPTH         = 16;
   localparam int RANDOM_ITEMS  = 310;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 40;

   // Operation codes that the block takes and ignores.
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   typedef struct {
      logic [2:0] op;
      word_type   word;
      int         gap;
      bit         drain;
   } deque_req_type;

   typedef struct {
      word_type   word;
      status_type status;
      logic       last;
   } deque_rsp_type;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic [2:0] req_operation = '0;
   word_type   req_word_in   = '0;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   word_type   rsp_word_out;
   status_type rsp_status;
   logic       rsp_last;

   deque_req_type queued_ops[$];
   deque_rsp_type awaited_answers[$];

   // Shadow of the queue contents.
   word_type   shadow_slots[DEPTH];
   int         shadow_front = 0;
   int         shadow_count = 0;

   bit         req_taken   = 1'b0;
   bit         gap_loaded  = 1'b0;
   int         gap_left    = 0;
   int         stall_left  = 0;
   int         calm_left   = 0;
   int         idle_cycles = 0;
   int         failures    = 0;

   bounded_deque_engine_unit #(.DEPTH(DEPTH)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_word_in   (req_word_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word_out  (rsp_word_out),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic word_type pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return 32'sh0000_0000;
         3:       return -32'sd1;
         default: return word_type'($urandom);
      endcase
   endfunction

   task automatic add_op(input logic [2:0] op, input word_type w, input int gap,
                         input bit drain);
      queued_ops.push_back('{op, w, gap, drain});
   endtask

   task automatic await_answer(input word_type w, input status_type s, input logic l);
      awaited_answers.push_back('{w, s, l});
   endtask

   // Applies one taken request to the shadow queue and queues its answers.
   task automatic model_deque_op(input logic [2:0] op, input word_type w);
      int pos;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (shadow_count >= DEPTH) begin
               await_answer('0, ST_FULL, 1'b1);
            end else begin
               if (op == OP_PUSH_FRONT) begin
                  shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                  shadow_slots[shadow_front] = w;
               end else begin
                  shadow_slots[(shadow_front + shadow_count) % DEPTH] = w;
               end
               shadow_count++;
               await_answer('0, ST_OK, 1'b1);
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (shadow_count == 0) begin
               await_answer('0, ST_EMPTY, 1'b1);
            end else begin
               if (op == OP_POP_FRONT) begin
                  pos = shadow_front;
                  shadow_front = (shadow_front + 1) % DEPTH;
               end else begin
                  pos = (shadow_front + shadow_count - 1) % DEPTH;
               end
               shadow_count--;
               await_answer(shadow_slots[pos], ST_OK, 1'b1);
            end
         end
         OP_LIST: begin
            if (shadow_count == 0) begin
               await_answer('0, ST_EMPTY, 1'b1);
            end else begin
               for (int i = 0; i < shadow_count; i++) begin
                  await_answer(shadow_slots[(shadow_front + i) % DEPTH], ST_OK,
                               logic'(i + 1 == shadow_count));
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   // Request driver: holds each word until it is taken, then waits out the
   // next word's gap. A word marked drain waits for every answer to arrive.
   always @(negedge clock) begin : req_driver
      bit hold;
      if (!reset) begin
         if (req_valid && req_taken) begin
            void'(queued_ops.pop_front());
            gap_loaded = 1'b0;
         end
         hold = req_valid && !req_taken;
         if (!hold) begin
            if (queued_ops.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               if (!gap_loaded) begin
                  gap_left   = queued_ops[0].gap;
                  gap_loaded = 1'b1;
               end
               if (gap_left > 0) begin
                  gap_left--;
                  req_valid <= 1'b0;
               end else if (queued_ops[0].drain && awaited_answers.size() != 0) begin
                  req_valid <= 1'b0;
               end else begin
                  req_valid     <= 1'b1;
                  req_operation <= queued_ops[0].op;
                  req_word_in   <= queued_ops[0].word;
               end
            end
         end
      end
   end

   // Answer-side back pressure, with calm stretches of constant ready.
   always @(negedge clock) begin : rsp_pacer
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (calm_left > 0) begin
            calm_left--;
         end else if ($urandom_range(0, 99) == 0) begin
            calm_left = $urandom_range(30, 100);
         end else if ($urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
      end
   end

   // Monitor: checks answers against the oldest prediction, then predicts
   // the answers of a request taken at the same edge.
   always @(posedge clock) begin : rsp_monitor
      deque_rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (awaited_answers.size() == 0) begin
               $error("unexpected answer word: word_out %0d status %0d last %0d",
                      rsp_word_out, rsp_status, rsp_last);
               failures++;
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_word_out !== want.word) begin
                  $error("word_out: expected %0d, got %0d", want.word, rsp_word_out);
                  failures++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  failures++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) model_deque_op(req_operation, req_word_in);

         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("CHECK FAILED");
               $finish;
            end
         end
      end
   end

   initial begin : stimulus
      int         kind;
      int         len;
      int         produced;
      bit         calm;
      bit         drain_next;
      logic [2:0] op;
      word_type   w;

      // Empty queue: list and both pops report empty.
      add_op(OP_LIST, pick_word(), pick_gap(), 1'b0);
      add_op(OP_POP_FRONT, pick_word(), pick_gap(), 1'b0);
      add_op(OP_POP_BACK, pick_word(), pick_gap(), 1'b0);
      // Fill to the brim from both ends, extreme words first.
      for (int k = 0; k < DEPTH; k++) begin
         case (k)
            0:       w = 32'sh8000_0000;
            1:       w = 32'sh7fff_ffff;
            2:       w = 32'sh0000_0000;
            3:       w = -32'sd1;
            default: w = word_type'($urandom);
         endcase
         add_op((k % 2 == 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, w, pick_gap(), 1'b0);
      end
      // Full queue drops pushes; a full list walks every entry.
      add_op(OP_PUSH_FRONT, pick_word(), pick_gap(), 1'b0);
      add_op(OP_PUSH_BACK, pick_word(), pick_gap(), 1'b0);
      add_op(OP_LIST, pick_word(), pick_gap(), 1'b0);
      add_op(OP_POP_FRONT, pick_word(), pick_gap(), 1'b0);
      add_op(OP_POP_BACK, pick_word(), pick_gap(), 1'b0);
      add_op(OP_SPARE_FIRST, pick_word(), pick_gap(), 1'b0);
      add_op(OP_SPARE_LAST, pick_word(), pick_gap(), 1'b0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Random part in runs: push runs, pop runs, mixed runs and noise.
      produced   = 0;
      drain_next = 1'b1;
      while (produced < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         len  = $urandom_range(1, 20);
         calm = ($urandom_range(0, 5) == 0);
         for (int k = 0; k < len; k++) begin
            if (kind <= 2) begin
               op = ($urandom_range(0, 7) == 0) ? OP_LIST
                                                : 3'($urandom_range(OP_PUSH_FRONT, OP_PUSH_BACK));
            end else if (kind <= 5) begin
               op = ($urandom_range(0, 5) == 0) ? OP_LIST
                                                : 3'($urandom_range(OP_POP_FRONT, OP_POP_BACK));
            end else if (kind <= 7) begin
               op = 3'($urandom_range(OP_PUSH_FRONT, OP_LIST));
            end else begin
               op = 3'($urandom_range(0, 7));
            end
            add_op(op, pick_word(), calm ? 0 : pick_gap(), drain_next);
            drain_next = 1'b0;
            if (op <= OP_LIST) produced++;
         end
         if ($urandom_range(0, 7) == 0) drain_next = 1'b1;
      end

      while (queued_ops.size() != 0 || awaited_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
